### hdl/kl_pkg.sv
// ----------------------------------------------------------------------------
// kl_pkg: shared types, constants and helpers of the keyword lexer
// Character classes, keyword matching, symbol decoding and token codes.
// ----------------------------------------------------------------------------
package kl_pkg;

    localparam int MAX_SOURCE = 65536;
    localparam int POS_W      = $clog2(MAX_SOURCE);
    localparam int KW_COUNT   = 3;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [15:0] KW3_LEN = 16'd3;
    localparam logic [15:0] KW4_LEN = 16'd4;

    // Token type codes
    localparam logic [3:0] TOK_IDENT   = 4'd0;
    localparam logic [3:0] TOK_KEYWORD = 4'd1;
    localparam logic [3:0] TOK_NUMBER  = 4'd2;
    localparam logic [3:0] TOK_STRING  = 4'd3;
    localparam logic [3:0] TOK_EOF     = 4'd4;
    localparam logic [3:0] TOK_SEMI    = 4'd5;
    localparam logic [3:0] TOK_RPAREN  = 4'd6;
    localparam logic [3:0] TOK_LPAREN  = 4'd7;
    localparam logic [3:0] TOK_RBRACE  = 4'd8;
    localparam logic [3:0] TOK_LBRACE  = 4'd9;
    localparam logic [3:0] TOK_COMMA   = 4'd10;
    localparam logic [3:0] TOK_COLON   = 4'd11;

    // Characters of interest
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_COMMENT,
        MODE_STOP
    } mode_t;

    typedef struct packed {
        logic [3:0]  token_type;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        error;
        logic        last_in_run;
    } result_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Bit i is set when keyword i (set, put, tile) has character c at this offset.
    function automatic logic [KW_COUNT-1:0] kw_match(input logic [7:0] c,
                                                     input logic [15:0] offset);
        logic [KW_COUNT-1:0] m;
        m = '0;
        case (offset)
            16'd0: m = {c == "t", c == "p", c == "s"};
            16'd1: m = {c == "i", c == "u", c == "e"};
            16'd2: m = {c == "l", c == "t", c == "t"};
            16'd3: m = {c == "e", 1'b0, 1'b0};
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] close_type(input mode_t mode,
                                              input logic [KW_COUNT-1:0] hits,
                                              input logic [15:0] len);
        logic kw;
        kw = (hits[0] && len == KW3_LEN) || (hits[1] && len == KW3_LEN) ||
             (hits[2] && len == KW4_LEN);
        if (mode == MODE_IDENT) begin
            return kw ? TOK_KEYWORD : TOK_IDENT;
        end
        return TOK_NUMBER;
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c == CH_SEMI || c == CH_RPAREN || c == CH_LPAREN || c == CH_RBRACE ||
               c == CH_LBRACE || c == CH_COMMA || c == CH_COLON;
    endfunction

    function automatic logic [3:0] symbol_type(input logic [7:0] c);
        logic [3:0] t;
        case (c)
            CH_SEMI:   t = TOK_SEMI;
            CH_RPAREN: t = TOK_RPAREN;
            CH_LPAREN: t = TOK_LPAREN;
            CH_RBRACE: t = TOK_RBRACE;
            CH_LBRACE: t = TOK_LBRACE;
            CH_COMMA:  t = TOK_COMMA;
            CH_COLON:  t = TOK_COLON;
            default:   t = TOK_SEMI;
        endcase
        return t;
    endfunction

endpackage

### hdl/keyword_lexer_core.sv
// ----------------------------------------------------------------------------
// keyword_lexer_core: streaming tokenizer for a small keyword language
// The first token of a request is on the m_ ports in the cycle after the
// request is accepted. Throughput: one character per cycle while m_ready is high
// and every character yields at most one token; a character that yields two or three
// tokens holds s_ready low until its tokens drain, one per cycle while m_ready is high.
// Reset (aresetn low, synchronous) clears the lexer state and the result queue.
// ----------------------------------------------------------------------------
module keyword_lexer_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_ch,
    input  logic                   s_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [3:0]             m_token_type,
    output logic [15:0]            m_token_start,
    output logic [15:0]            m_token_length,
    output logic                   m_error,
    output logic                   m_last_in_run
);
    import kl_pkg::*;

    // Lexer state
    mode_t                 mode_reg, mode_next, mode_mid;
    logic [POS_W-1:0]      position_reg, position_next;
    logic [15:0]           run_start_reg, run_start_next, start_mid;
    logic [15:0]           run_len_reg, run_len_next, len_mid;
    logic [KW_COUNT-1:0]   hits_reg, hits_next, hits_mid;
    logic                  slash_pending_reg, slash_pending_next, slash_mid;

    // Result queue: slot 0 drives the output ports
    result_t               slot_reg [3];
    result_t               slot_next [3];
    logic [1:0]            count_reg, count_next;

    logic                  accept, take;
    logic                  letter, digit, quote, slash, newline;
    logic                  stopped, close1, str_ok, str_err;
    logic                  idle_handle, comment_start, idle_proc;
    logic [15:0]           grown_len, pos16;
    result_t               cand [4];
    logic [3:0]            cand_v;
    result_t               new_slot [3];
    logic [2:0]            new_count;
    logic                  new_error;

    assign accept  = s_valid && s_ready;
    assign take    = m_valid && m_ready;
    assign s_ready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign pos16   = 16'(position_reg);

    // Character classes and the events of this character
    always_comb begin
        letter        = is_letter(s_ch);
        digit         = is_digit(s_ch);
        quote         = s_ch == CH_QUOTE;
        slash         = s_ch == CH_SLASH;
        newline       = s_ch == CH_NEWLINE;
        stopped       = mode_reg == MODE_STOP;
        close1        = (mode_reg == MODE_IDENT && !letter) ||
                        (mode_reg == MODE_NUMBER && !digit);
        str_ok        = mode_reg == MODE_STRING && quote;
        str_err       = mode_reg == MODE_STRING && !quote && (newline || s_last);
        // A closed run hands its terminating character to the idle handling.
        idle_handle   = mode_reg == MODE_IDLE || close1;
        comment_start = idle_handle && slash_pending_reg && slash;
        idle_proc     = idle_handle && !comment_start;
        grown_len     = (run_len_reg == LEN_MAX) ? run_len_reg : run_len_reg + 16'd1;
    end

    // Next state
    always_comb begin
        mode_mid  = mode_reg;
        start_mid = run_start_reg;
        len_mid   = run_len_reg;
        hits_mid  = hits_reg;
        slash_mid = slash_pending_reg;

        unique case (mode_reg)
            MODE_IDENT: begin
                if (letter) begin
                    hits_mid = hits_reg & kw_match(s_ch, run_len_reg);
                    len_mid  = grown_len;
                end else begin
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (digit) begin
                    len_mid = grown_len;
                end else begin
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_STRING: begin
                len_mid = grown_len;
                if (quote) begin
                    mode_mid = MODE_IDLE;
                end else if (newline || s_last) begin
                    mode_mid = MODE_STOP;
                end
            end
            MODE_COMMENT: begin
                if (newline) begin
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_IDLE, MODE_STOP: begin
            end
            default: begin
            end
        endcase

        if (idle_handle) begin
            slash_mid = 1'b0;
        end
        if (comment_start) begin
            mode_mid = MODE_COMMENT;
        end
        if (idle_proc) begin
            if (slash) begin
                slash_mid = 1'b1;
            end else if (letter) begin
                mode_mid  = MODE_IDENT;
                start_mid = pos16;
                len_mid   = 16'd1;
                hits_mid  = kw_match(s_ch, 16'd0);
            end else if (digit) begin
                mode_mid  = MODE_NUMBER;
                start_mid = pos16;
                len_mid   = 16'd1;
            end else if (quote) begin
                start_mid = pos16;
                len_mid   = 16'd1;
                mode_mid  = s_last ? MODE_STOP : MODE_STRING;
            end
        end

        mode_next          = mode_mid;
        run_start_next     = start_mid;
        run_len_next       = len_mid;
        hits_next          = hits_mid;
        slash_pending_next = slash_mid;
        position_next      = (position_reg == POS_W'(MAX_SOURCE - 1)) ? '0
                                                                      : position_reg + 1'b1;
        if (stopped) begin
            mode_next          = mode_reg;
            run_start_next     = run_start_reg;
            run_len_next       = run_len_reg;
            hits_next          = hits_reg;
            slash_pending_next = slash_pending_reg;
            position_next      = position_reg;
        end
        // The end of source returns the lexer state to its reset value.
        if (s_last) begin
            mode_next          = MODE_IDLE;
            run_start_next     = '0;
            run_len_next       = '0;
            hits_next          = '1;
            slash_pending_next = 1'b0;
            position_next      = '0;
        end
    end

    // Tokens caused by this character, in emission order
    always_comb begin
        cand_v[0] = close1 || str_ok || str_err;
        cand[0]   = '0;
        if (close1) begin
            cand[0].token_type   = close_type(mode_reg, hits_reg, run_len_reg);
            cand[0].token_start  = run_start_reg;
            cand[0].token_length = run_len_reg;
        end else begin
            cand[0].token_type   = TOK_STRING;
            cand[0].token_start  = run_start_reg;
            cand[0].token_length = grown_len;
            cand[0].error        = str_err;
        end

        cand_v[1] = idle_proc && !slash && !letter && !digit &&
                    ((quote && s_last) || is_symbol(s_ch));
        cand[1]   = '0;
        cand[1].token_start  = pos16;
        cand[1].token_length = 16'd1;
        if (quote) begin
            cand[1].token_type = TOK_STRING;
            cand[1].error      = 1'b1;
        end else begin
            cand[1].token_type = symbol_type(s_ch);
        end

        cand_v[2] = s_last && !stopped && (mode_mid == MODE_IDENT || mode_mid == MODE_NUMBER);
        cand[2]   = '0;
        cand[2].token_type   = close_type(mode_mid, hits_mid, len_mid);
        cand[2].token_start  = start_mid;
        cand[2].token_length = len_mid;

        cand_v[3] = s_last && !stopped && mode_mid != MODE_STOP;
        cand[3]   = '0;
        cand[3].token_type = TOK_EOF;
    end

    // Pack the valid candidates into the front of a three-entry list.
    always_comb begin
        new_count = 3'd0;
        new_error = 1'b0;
        for (int i = 0; i < 3; i++) begin
            new_slot[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && new_count < 3'd3) begin
                new_slot[new_count[1:0]] = cand[i];
                new_error                = new_error | cand[i].error;
                new_count                = new_count + 3'd1;
            end
        end
        if (new_count != 3'd0) begin
            new_slot[2'(new_count - 3'd1)].last_in_run = 1'b1;
        end
    end

    // Result queue update
    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < 3; i++) begin
            slot_next[i] = slot_reg[i];
        end
        if (accept) begin
            count_next = new_count[1:0];
            for (int i = 0; i < 3; i++) begin
                slot_next[i] = new_slot[i];
            end
        end else if (take) begin
            count_next   = count_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_IDLE;
            position_reg      <= '0;
            run_start_reg     <= '0;
            run_len_reg       <= '0;
            hits_reg          <= '1;
            slash_pending_reg <= 1'b0;
            count_reg         <= 2'd0;
        end else begin
            if (accept) begin
                mode_reg          <= mode_next;
                position_reg      <= position_next;
                run_start_reg     <= run_start_next;
                run_len_reg       <= run_len_next;
                hits_reg          <= hits_next;
                slash_pending_reg <= slash_pending_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign m_valid        = count_reg != 2'd0;
    assign m_token_type   = slot_reg[0].token_type;
    assign m_token_start  = slot_reg[0].token_start;
    assign m_token_length = slot_reg[0].token_length;
    assign m_error        = slot_reg[0].error;
    assign m_last_in_run  = slot_reg[0].last_in_run;

    // A stopped lexer produces no tokens.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode_reg == MODE_STOP) |=> count_reg == 2'd0)
        else $error("stopped lexer produced a token");

    // The end of source always yields at least one token unless already stopped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last && mode_reg != MODE_STOP) |=> count_reg != 2'd0)
        else $error("end of source gave no token");

    // An unterminated string in the middle of a source stops the lexer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && new_error && !s_last) |=> mode_reg == MODE_STOP)
        else $error("string error did not stop the lexer");

    // The end of source re-arms the lexer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last) |=> (mode_reg == MODE_IDLE && position_reg == '0 &&
                                !slash_pending_reg))
        else $error("lexer not re-armed after end of source");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for keyword_lexer_core
// Feeds source text one character per request and predicts every token in a
// behavioral lexer kept alongside the block. Each token that leaves the m_
// channel is compared field by field against the oldest predicted token.
// Both channels idle at random. Directed sources come first, then random
// sources built mostly from well-formed tokens.
// ----------------------------------------------------------------------------
module tb_top;
    import kl_pkg::*;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch           = 8'h00;
    logic        s_last         = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [3:0]  m_token_type;
    logic [15:0] m_token_start;
    logic [15:0] m_token_length;
    logic        m_error;
    logic        m_last_in_run;

    keyword_lexer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_type   (m_token_type),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_error        (m_error),
        .m_last_in_run  (m_last_in_run)
    );

    // Predicted tokens, oldest first, and the tokens of the character in work.
    result_t     token_q[$];
    result_t     step_toks[$];
    logic [7:0]  src_bytes[$];
    int          mismatch_cnt   = 0;

    // Behavioral lexer state.
    mode_t       lx_mode;
    logic [15:0] lx_pos;
    logic [15:0] lx_start;
    logic [15:0] lx_len;
    logic [2:0]  lx_hits;
    logic        lx_slash;
    string       kw_word[3]     = '{"set", "put", "tile"};

    // Sender and receiver pacing.
    bit          allow_gaps     = 1'b1;
    int          burst_left     = 0;
    int          stall_mode     = 0;
    int          stall_left     = 0;
    result_t     got_tok;
    result_t     want_tok;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 1_500_000);
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic bit letter_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Drops every keyword that does not have character c at this offset.
    function automatic logic [2:0] narrow_hits(input logic [2:0] hits,
                                               input logic [7:0] c,
                                               input logic [15:0] offset);
        int off;
        off = offset;
        for (int i = 0; i < 3; i++) begin
            if (hits[i] && (off >= kw_word[i].len() || kw_word[i][off] != c)) begin
                hits[i] = 1'b0;
            end
        end
        return hits;
    endfunction

    function automatic void clear_lexer();
        lx_mode  = MODE_IDLE;
        lx_pos   = '0;
        lx_start = '0;
        lx_len   = '0;
        lx_hits  = 3'b111;
        lx_slash = 1'b0;
    endfunction

    function automatic void queue_token(input logic [3:0] kind, input logic [15:0] start,
                                        input logic [15:0] len, input logic err);
        result_t t;
        t.token_type   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.error        = err;
        t.last_in_run  = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void close_run();
        logic [3:0] kind;
        kind = TOK_NUMBER;
        if (lx_mode == MODE_IDENT) begin
            kind = TOK_IDENT;
            for (int i = 0; i < 3; i++) begin
                if (lx_hits[i] && lx_len == 16'(kw_word[i].len())) begin
                    kind = TOK_KEYWORD;
                end
            end
        end
        queue_token(kind, lx_start, lx_len, 1'b0);
        lx_mode = MODE_IDLE;
    endfunction

    function automatic void grow_run();
        if (lx_len != LEN_MAX) begin
            lx_len = lx_len + 16'd1;
        end
    endfunction

    // Advances the lexer by one accepted character and queues its tokens.
    function automatic void lex_char(input logic [7:0] c, input logic lst);
        bit taken;
        taken = 1'b0;
        step_toks.delete();
        if (lx_mode == MODE_STOP) begin
            if (lst) begin
                clear_lexer();
            end
            return;
        end
        case (lx_mode)
            MODE_IDENT: begin
                if (letter_char(c)) begin
                    lx_hits = narrow_hits(lx_hits, c, lx_len);
                    grow_run();
                    taken = 1'b1;
                end else begin
                    close_run();
                end
            end
            MODE_NUMBER: begin
                if (digit_char(c)) begin
                    grow_run();
                    taken = 1'b1;
                end else begin
                    close_run();
                end
            end
            MODE_STRING: begin
                taken = 1'b1;
                grow_run();
                if (c == CH_QUOTE) begin
                    queue_token(TOK_STRING, lx_start, lx_len, 1'b0);
                    lx_mode = MODE_IDLE;
                end else if (c == CH_NEWLINE || lst) begin
                    queue_token(TOK_STRING, lx_start, lx_len, 1'b1);
                    lx_mode = MODE_STOP;
                end
            end
            MODE_COMMENT: begin
                taken = 1'b1;
                if (c == CH_NEWLINE) begin
                    lx_mode = MODE_IDLE;
                end
            end
            default: ;
        endcase
        if (!taken && lx_slash) begin
            lx_slash = 1'b0;
            if (c == CH_SLASH) begin
                lx_mode = MODE_COMMENT;
                taken   = 1'b1;
            end
        end
        if (!taken) begin
            if (c == CH_SLASH) begin
                lx_slash = 1'b1;
            end else if (letter_char(c)) begin
                lx_mode  = MODE_IDENT;
                lx_start = lx_pos;
                lx_len   = 16'd1;
                lx_hits  = narrow_hits(3'b111, c, 16'd0);
            end else if (digit_char(c)) begin
                lx_mode  = MODE_NUMBER;
                lx_start = lx_pos;
                lx_len   = 16'd1;
            end else if (c == CH_QUOTE) begin
                lx_start = lx_pos;
                lx_len   = 16'd1;
                if (lst) begin
                    queue_token(TOK_STRING, lx_start, lx_len, 1'b1);
                    lx_mode = MODE_STOP;
                end else begin
                    lx_mode = MODE_STRING;
                end
            end else begin
                case (c)
                    CH_SEMI:   queue_token(TOK_SEMI, lx_pos, 16'd1, 1'b0);
                    CH_RPAREN: queue_token(TOK_RPAREN, lx_pos, 16'd1, 1'b0);
                    CH_LPAREN: queue_token(TOK_LPAREN, lx_pos, 16'd1, 1'b0);
                    CH_RBRACE: queue_token(TOK_RBRACE, lx_pos, 16'd1, 1'b0);
                    CH_LBRACE: queue_token(TOK_LBRACE, lx_pos, 16'd1, 1'b0);
                    CH_COMMA:  queue_token(TOK_COMMA, lx_pos, 16'd1, 1'b0);
                    CH_COLON:  queue_token(TOK_COLON, lx_pos, 16'd1, 1'b0);
                    default: ;
                endcase
            end
        end
        lx_pos = lx_pos + 16'd1;
        if (lst) begin
            if (lx_mode != MODE_STOP) begin
                if (lx_mode == MODE_IDENT || lx_mode == MODE_NUMBER) begin
                    close_run();
                end
                queue_token(TOK_EOF, 16'd0, 16'd0, 1'b0);
            end
            clear_lexer();
        end
        if (step_toks.size() > 0) begin
            step_toks[step_toks.size() - 1].last_in_run = 1'b1;
        end
        foreach (step_toks[i]) begin
            token_q.push_back(step_toks[i]);
        end
    endfunction

    // Sends one character; called and returns at a falling edge.
    task automatic send_char(input logic [7:0] c, input logic lst);
        int gap_len;
        if (allow_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if (gap_len > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap_len) @(negedge aclk);
                end
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        s_last  <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lex_char(c, lst);
        @(negedge aclk);
    endtask

    task automatic send_text(input string text, input bit ends_source);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i], ends_source && i == text.len() - 1);
        end
    endtask

    // Holds the input channel until every predicted token has come out.
    task automatic drain_tokens();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (token_q.size() != 0) @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input result_t want,
                                 input result_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t %s: expected type %0d start %0d len %0d err %0d end %0d,",
                     $realtime, what, want.token_type, want.token_start,
                     want.token_length, want.error, want.last_in_run);
            $display("    got type %0d start %0d len %0d err %0d end %0d",
                     got.token_type, got.token_start, got.token_length, got.error,
                     got.last_in_run);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_tok = '{m_token_type, m_token_start, m_token_length, m_error,
                        m_last_in_run};
            if (token_q.size() == 0) begin
                note_mismatch("token with none predicted", '0, got_tok);
            end else begin
                want_tok = token_q.pop_front();
                if (got_tok.token_type !== want_tok.token_type ||
                    got_tok.token_start !== want_tok.token_start ||
                    got_tok.token_length !== want_tok.token_length ||
                    got_tok.error !== want_tok.error ||
                    got_tok.last_in_run !== want_tok.last_in_run) begin
                    note_mismatch("token mismatch", want_tok, got_tok);
                end
            end
        end
    end

    // The receiver switches between stall patterns at random intervals.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= stall_left[2];
        endcase
    end

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end
        return CH_UNDER;
    endfunction

    // Any byte that keeps a string or a comment open.
    function automatic logic [7:0] rand_inner_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_QUOTE || b == CH_NEWLINE);
        return b;
    endfunction

    function automatic void push_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            src_bytes.push_back(text[i]);
        end
    endfunction

    // Builds one source, mostly well-formed tokens with random content.
    function automatic void build_source();
        logic [7:0] syms[7] = '{CH_SEMI, CH_RPAREN, CH_LPAREN, CH_RBRACE,
                                CH_LBRACE, CH_COMMA, CH_COLON};
        string      near_kw[6] = '{"se", "sett", "pu", "puts", "til", "tiles"};
        int         n_tok;
        int         n;
        src_bytes.delete();
        n_tok = $urandom_range(1, 10);
        for (int k = 0; k < n_tok; k++) begin
            case ($urandom_range(0, 11))
                0: push_text(kw_word[$urandom_range(0, 2)]);
                1: begin
                    if ($urandom_range(0, 2) == 0) begin
                        push_text(near_kw[$urandom_range(0, 5)]);
                    end else begin
                        n = $urandom_range(1, 6);
                        repeat (n) src_bytes.push_back(rand_letter());
                    end
                end
                2: begin
                    n = $urandom_range(1, 5);
                    repeat (n) src_bytes.push_back(8'("0" + $urandom_range(0, 9)));
                end
                3: begin
                    src_bytes.push_back(CH_QUOTE);
                    n = $urandom_range(0, 5);
                    repeat (n) src_bytes.push_back(rand_inner_byte());
                    src_bytes.push_back(CH_QUOTE);
                end
                4: begin
                    push_text("//");
                    n = $urandom_range(0, 4);
                    repeat (n) src_bytes.push_back(rand_inner_byte());
                    src_bytes.push_back(CH_NEWLINE);
                end
                5, 6: src_bytes.push_back(syms[$urandom_range(0, 6)]);
                7: begin
                    case ($urandom_range(0, 2))
                        0:       src_bytes.push_back(CH_SPACE);
                        1:       src_bytes.push_back(CH_NEWLINE);
                        default: src_bytes.push_back("\r");
                    endcase
                end
                8: src_bytes.push_back(8'($urandom_range(128, 255)));
                9: src_bytes.push_back(CH_SLASH);
                10: src_bytes.push_back(8'($urandom_range(0, 255)));
                default: begin
                    // Broken string, rare: an opening quote with no closing one, sometimes followed by a newline.
                    if ($urandom_range(0, 2) == 0) begin
                        src_bytes.push_back(CH_QUOTE);
                        n = $urandom_range(0, 3);
                        repeat (n) src_bytes.push_back(rand_inner_byte());
                        if ($urandom_range(0, 1) == 0) begin
                            src_bytes.push_back(CH_NEWLINE);
                        end
                    end else begin
                        src_bytes.push_back(CH_SPACE);
                    end
                end
            endcase
            if ($urandom_range(0, 1) == 0) begin
                src_bytes.push_back(CH_SPACE);
            end
        end
    endfunction

    task automatic test_keywords();
        send_text("set put tile sets se Set tilE _til", 1'b1);
    endtask

    task automatic test_numbers_symbols();
        send_text("09;)(}{,:7a", 1'b1);
    endtask

    task automatic test_skipping();
        send_text("//a/\"\r\n/x/", 1'b0);
        send_char("\t", 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_text(" b/", 1'b1);
    endtask

    task automatic test_strings();
        send_text("\"a/\r;\" \"x\nq; ;", 1'b1);
        send_text("\"", 1'b1);
        send_text("\"ab", 1'b1);
    endtask

    task automatic test_run_end();
        send_text("ab;", 1'b1);
        send_text("12:", 1'b1);
        send_text(" ", 1'b1);
    endtask

    // A long identifier sent back to back with no gaps, closed by a symbol
    // that also ends the source.
    task automatic test_long_run();
        allow_gaps = 1'b0;
        for (int i = 0; i < 12; i++) begin
            send_char(rand_letter(), 1'b0);
        end
        send_char(CH_SEMI, 1'b1);
        allow_gaps = 1'b1;
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 20) begin
            build_source();
            foreach (src_bytes[i]) begin
                send_char(src_bytes[i], i == src_bytes.size() - 1);
            end
            sent += src_bytes.size();
        end
    endtask

    initial begin
        clear_lexer();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_keywords();
        test_numbers_symbols();
        drain_tokens();
        test_skipping();
        test_strings();
        test_run_end();
        drain_tokens();
        test_long_run();
        test_random();

        drain_tokens();
        repeat (8) @(posedge aclk);
        if (token_q.size() != 0) begin
            note_mismatch("predicted token never came", token_q[0], '0);
        end
        if (mismatch_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
